### hw/rtl/pbop_pkg.sv
// Shared types and constants for the packet buffer ownership pool.
// No dependencies; imported by every module of the block.
package pbop_pkg;

    localparam int OP_W        = 3;
    localparam int ID_FIELD_W  = 3;
    localparam int LEN_W       = 12;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 32;

    typedef enum logic [OP_W-1:0] {
        OP_CLAIM_RX = 3'd0,
        OP_CLAIM_FREE = 3'd1,
        OP_START_TX = 3'd2,
        OP_FREE = 3'd3,
        OP_RX_DONE = 3'd4,
        OP_TX_DONE = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        OWN_FREE  = 2'd0,
        OWN_HW    = 2'd1,
        OWN_CPU   = 2'd2,
        OWN_VALID = 2'd3
    } own_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOBUF  = 2'd1,
        ST_TXBUSY = 2'd2,
        ST_NOTCPU = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_SCAN,
        S_DONE
    } state_t;

    // Result of one item, as handed from the sequencer to the output register.
    typedef struct packed {
        logic                  tx_active;
        logic [LEN_W-1:0]      tx_length;
        logic [ID_FIELD_W-1:0] tx_source_id;
        logic                  rx_armed;
        logic [ID_FIELD_W-1:0] rx_target_id;
        logic [ID_FIELD_W-1:0] granted_id;
        status_t               status;
    } result_t;

endpackage

### hw/rtl/pbop_owner_mem.sv
// Ownership table: one 2-bit owner code per buffer, one write and one
// registered read per cycle. Per-entry valid bits give the reset contents.
// Depends on pbop_pkg.
module pbop_owner_mem
    import pbop_pkg::*;
#(
    parameter int NUM_BUFFERS = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           rd_en,
    input  logic [$clog2(NUM_BUFFERS)-1:0] rd_addr,
    output own_t                           rd_data,
    input  logic                           wr_en,
    input  logic [$clog2(NUM_BUFFERS)-1:0] wr_addr,
    input  own_t                           wr_data
);

    localparam int ID_W = $clog2(NUM_BUFFERS);

    own_t                   owner_reg [NUM_BUFFERS];
    logic [NUM_BUFFERS-1:0] valid_reg;
    own_t                   rd_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            owner_reg[wr_addr] <= wr_data;
        end
    end

    // Entry 0 comes out of reset as the receive target, the rest free.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (valid_reg[rd_addr]) begin
                rd_data_reg <= owner_reg[rd_addr];
            end else if (rd_addr == ID_W'(0)) begin
                rd_data_reg <= OWN_HW;
            end else begin
                rd_data_reg <= OWN_FREE;
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/pbop_ctrl.sv
// Operation sequencer: decodes one item, scans the ownership table one entry
// a cycle, updates receive/transmit state. Depends on pbop_pkg, pbop_owner_mem.
module pbop_ctrl
    import pbop_pkg::*;
#(
    parameter int NUM_BUFFERS  = 8,
    parameter int BUFFER_BYTES = 2048
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [OP_W-1:0]       start_op,
    input  logic [ID_FIELD_W-1:0] start_id,
    input  logic [LEN_W-1:0]      start_len,
    output logic                  idle,
    output logic                  res_valid,
    input  logic                  res_ready,
    output result_t               res
);

    localparam int ID_W  = $clog2(NUM_BUFFERS);
    localparam int CNT_W = $clog2(NUM_BUFFERS + 1);

    state_t           state_reg, state_next;
    op_t              op_reg, op_next;
    logic [ID_W-1:0]  id_reg, id_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [ID_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0] issue_cnt_reg, issue_cnt_next;
    logic             pend_reg, pend_next;
    logic             pend_last_reg, pend_last_next;
    logic [ID_W-1:0]  pend_idx_reg, pend_idx_next;
    logic [ID_W-1:0]  last_claimed_reg, last_claimed_next;
    logic [ID_W-1:0]  rx_current_reg, rx_current_next;
    logic             rx_armed_reg, rx_armed_next;
    logic [ID_W-1:0]  tx_current_reg, tx_current_next;
    logic             tx_busy_reg, tx_busy_next;
    logic [LEN_W-1:0] tx_length_reg, tx_length_next;
    status_t          status_reg, status_next;
    logic [ID_W-1:0]  granted_reg, granted_next;

    logic             rd_en;
    logic [ID_W-1:0]  rd_addr;
    own_t             rd_data;
    logic             wr_en;
    logic [ID_W-1:0]  wr_addr;
    own_t             wr_data;
    own_t             scan_target;
    logic             in_range;

    pbop_owner_mem #(
        .NUM_BUFFERS(NUM_BUFFERS)
    ) u_owner_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    function automatic logic [ID_W-1:0] next_idx(input logic [ID_W-1:0] i);
        return (i == ID_W'(NUM_BUFFERS - 1)) ? '0 : i + ID_W'(1);
    endfunction

    assign in_range    = (32'(start_id) < NUM_BUFFERS);
    assign scan_target = (op_reg == OP_CLAIM_RX) ? OWN_VALID : OWN_FREE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            pend_reg         <= 1'b0;
            pend_last_reg    <= 1'b0;
            last_claimed_reg <= '0;
            rx_current_reg   <= '0;
            rx_armed_reg     <= 1'b1;
            tx_current_reg   <= '0;
            tx_busy_reg      <= 1'b0;
            tx_length_reg    <= '0;
        end else begin
            state_reg        <= state_next;
            pend_reg         <= pend_next;
            pend_last_reg    <= pend_last_next;
            last_claimed_reg <= last_claimed_next;
            rx_current_reg   <= rx_current_next;
            rx_armed_reg     <= rx_armed_next;
            tx_current_reg   <= tx_current_next;
            tx_busy_reg      <= tx_busy_next;
            tx_length_reg    <= tx_length_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        id_reg        <= id_next;
        len_reg       <= len_next;
        idx_reg       <= idx_next;
        issue_cnt_reg <= issue_cnt_next;
        pend_idx_reg  <= pend_idx_next;
        status_reg    <= status_next;
        granted_reg   <= granted_next;
    end

    always_comb begin
        state_next        = state_reg;
        op_next           = op_reg;
        id_next           = id_reg;
        len_next          = len_reg;
        idx_next          = idx_reg;
        issue_cnt_next    = issue_cnt_reg;
        pend_next         = 1'b0;
        pend_last_next    = 1'b0;
        pend_idx_next     = pend_idx_reg;
        last_claimed_next = last_claimed_reg;
        rx_current_next   = rx_current_reg;
        rx_armed_next     = rx_armed_reg;
        tx_current_next   = tx_current_reg;
        tx_busy_next      = tx_busy_reg;
        tx_length_next    = tx_length_reg;
        status_next       = status_reg;
        granted_next      = granted_reg;
        rd_en             = 1'b0;
        rd_addr           = idx_reg;
        wr_en             = 1'b0;
        wr_addr           = id_reg;
        wr_data           = OWN_FREE;
        idle              = 1'b0;
        res_valid         = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                idle = 1'b1;
                if (start) begin
                    op_next        = op_t'(start_op);
                    id_next        = ID_W'(start_id);
                    len_next       = (32'(start_len) > BUFFER_BYTES) ?
                                     LEN_W'(BUFFER_BYTES) : start_len;
                    issue_cnt_next = '0;
                    status_next    = ST_OK;
                    granted_next   = '0;
                    state_next     = S_DONE;
                    rd_addr        = ID_W'(start_id);
                    unique case (start_op)
                        OP_CLAIM_RX: begin
                            idx_next   = next_idx(last_claimed_reg);
                            state_next = S_SCAN;
                        end
                        OP_CLAIM_FREE: begin
                            idx_next   = '0;
                            state_next = S_SCAN;
                        end
                        OP_START_TX: begin
                            if (tx_busy_reg) begin
                                status_next = ST_TXBUSY;
                            end else if (!in_range) begin
                                status_next = ST_NOTCPU;
                            end else begin
                                rd_en      = 1'b1;
                                state_next = S_LOOK;
                            end
                        end
                        OP_FREE: begin
                            if (in_range) begin
                                rd_en      = 1'b1;
                                state_next = S_LOOK;
                            end
                        end
                        OP_RX_DONE: begin
                            if (!rx_armed_reg) begin
                                status_next = ST_NOBUF;
                            end else begin
                                // filled buffer becomes valid, then hunt a free one
                                wr_en         = 1'b1;
                                wr_addr       = rx_current_reg;
                                wr_data       = OWN_VALID;
                                rx_armed_next = 1'b0;
                                idx_next      = next_idx(rx_current_reg);
                                state_next    = S_SCAN;
                            end
                        end
                        OP_TX_DONE: begin
                            if (tx_busy_reg) begin
                                tx_busy_next = 1'b0;
                                wr_en        = 1'b1;
                                wr_addr      = tx_current_reg;
                                if (rx_armed_reg) begin
                                    wr_data = OWN_FREE;
                                end else begin
                                    wr_data         = OWN_HW;
                                    rx_current_next = tx_current_reg;
                                    rx_armed_next   = 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_LOOK: begin
                state_next = S_DONE;
                if (op_reg == OP_START_TX) begin
                    if (rd_data == OWN_CPU) begin
                        wr_en           = 1'b1;
                        wr_data         = OWN_HW;
                        tx_current_next = id_reg;
                        tx_length_next  = len_reg;
                        tx_busy_next    = 1'b1;
                    end else begin
                        status_next = ST_NOTCPU;
                    end
                end else if (rd_data == OWN_CPU) begin
                    // free; re-arms a starved receiver
                    wr_en = 1'b1;
                    if (rx_armed_reg) begin
                        wr_data = OWN_FREE;
                    end else begin
                        wr_data         = OWN_HW;
                        rx_current_next = id_reg;
                        rx_armed_next   = 1'b1;
                    end
                end
            end

            S_SCAN: begin
                // read issue runs one entry ahead of the compare
                if (issue_cnt_reg != CNT_W'(NUM_BUFFERS)) begin
                    rd_en          = 1'b1;
                    rd_addr        = idx_reg;
                    idx_next       = next_idx(idx_reg);
                    issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                    pend_next      = 1'b1;
                    pend_last_next = (issue_cnt_reg == CNT_W'(NUM_BUFFERS - 1));
                    pend_idx_next  = idx_reg;
                end
                if (pend_reg && rd_data == scan_target) begin
                    pend_next   = 1'b0;
                    wr_en       = 1'b1;
                    wr_addr     = pend_idx_reg;
                    status_next = ST_OK;
                    state_next  = S_DONE;
                    if (op_reg == OP_RX_DONE) begin
                        wr_data         = OWN_HW;
                        rx_current_next = pend_idx_reg;
                        rx_armed_next   = 1'b1;
                    end else begin
                        wr_data      = OWN_CPU;
                        granted_next = pend_idx_reg;
                        if (op_reg == OP_CLAIM_RX) begin
                            last_claimed_next = pend_idx_reg;
                        end
                    end
                end else if (pend_reg && pend_last_reg) begin
                    pend_next   = 1'b0;
                    status_next = ST_NOBUF;
                    state_next  = S_DONE;
                end
            end

            S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        res.status       = status_reg;
        res.granted_id   = ID_FIELD_W'(granted_reg);
        res.rx_target_id = ID_FIELD_W'(rx_current_reg);
        res.rx_armed     = rx_armed_reg;
        res.tx_source_id = ID_FIELD_W'(tx_current_reg);
        res.tx_length    = tx_length_reg;
        res.tx_active    = tx_busy_reg;
    end

endmodule

### hw/rtl/packet_buffer_ownership_pool.sv
// Packet buffer ownership pool, top level: stream ports and result register.
// Depends on pbop_pkg, pbop_ctrl (which holds pbop_owner_mem).
//
// Usage:
//   Slave channel s_*: one item per operation (claim rx packet, claim free,
//   start tx, free, rx done, tx done). Master channel m_*: exactly one result
//   item per input item, in order, showing status, the granted buffer and the
//   receive/transmit state after the operation.
//   The owner table has one registered read port, and every search walks it
//   one entry a cycle. Claims and rx done search the table; start tx and free
//   read the named entry unless refused at once; the rest need no read.
//   One item is in work at a time: s_tready is high only while the sequencer
//   is idle, so a new item is taken only once the last result has left it.
//   The result sits in an output register; the next item is accepted while
//   it waits. If the receiver stalls, the following result waits inside the
//   sequencer and s_tready stays low until the register drains.
//   Reset (aresetn low, synchronous): buffer 0 is the receive target and
//   armed, all other buffers free, transmitter idle, no result pending.
//   Nothing needs clearing after reset; the block is ready at once.
module packet_buffer_ownership_pool
    import pbop_pkg::*;
#(
    parameter int NUM_BUFFERS  = 8,
    parameter int BUFFER_BYTES = 2048
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [2:0] operation, [5:3] buffer_id, [17:6] frame_length, rest zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [1:0] status, [4:2] granted_id, [7:5] rx_target_id, [8] rx_armed,
    // [11:9] tx_source_id, [23:12] tx_length_out, [24] tx_active, rest zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic                 ctrl_idle;
    logic                 res_valid;
    logic                 res_ready;
    result_t              res;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    pbop_ctrl #(
        .NUM_BUFFERS  (NUM_BUFFERS),
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_tvalid && s_tready),
        .start_op  (s_tdata[2:0]),
        .start_id  (s_tdata[5:3]),
        .start_len (s_tdata[17:6]),
        .idle      (ctrl_idle),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign s_tready  = ctrl_idle;
    // output register frees up in the same cycle it is taken
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = M_TDATA_W'(res);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### sim/tb_packet_buffer_ownership_pool.sv
// Self-checking testbench for packet_buffer_ownership_pool: a typed predictor
// of the buffer pool checks every result item, under random idling on both sides.
// Depends on pbop_pkg and the packet_buffer_ownership_pool RTL.
`timescale 1ns / 100ps

module tb_packet_buffer_ownership_pool;
    import pbop_pkg::*;

    localparam int NUM_BUFFERS  = 8;
    localparam int MAX_FRAME    = 2048;
    localparam int STALL_LIMIT  = 1000;   // cycles with no item moving on either side
    localparam int DRAIN_CYCLES = NUM_BUFFERS + 6;
    localparam int REPORT_MAX   = 10;
    localparam int RES_W        = $bits(result_t);

    // Opcodes the block has no use for; they must pass through unchanged.
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // [2:0] operation, [5:3] buffer_id, [17:6] frame_length, rest zero
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // [1:0] status, [4:2] granted_id, [7:5] rx_target_id, [8] rx_armed,
    // [11:9] tx_source_id, [23:12] tx_length_out, [24] tx_active, rest zero
    logic [M_TDATA_W-1:0] m_tdata;

    packet_buffer_ownership_pool #(
        .NUM_BUFFERS (NUM_BUFFERS),
        .BUFFER_BYTES(MAX_FRAME)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Pool predictor: ownership table plus rx/tx pointers, updated when an
    // item is accepted, so it always mirrors the block after the last item.
    // ------------------------------------------------------------------
    own_t            owner_tbl [NUM_BUFFERS];
    logic [2:0]      last_claim_id;
    logic [2:0]      rx_target;
    logic            rx_armed_q;
    logic [2:0]      tx_source;
    logic            tx_busy_q;
    logic [LEN_W-1:0] tx_len_q;

    result_t pool_results [$];   // expected result items, oldest first

    int unsigned mismatch_count = 0;
    int unsigned result_index   = 0;
    int unsigned sender_gap_pct = 0;   // chance of a gap after each sent item
    int unsigned stall_pct      = 0;   // chance of a m_tready stall per cycle

    // A buffer handed back goes straight to the receiver if it was starved.
    function automatic void release_buffer(input logic [2:0] id);
        owner_tbl[id] = OWN_FREE;
        if (!rx_armed_q) begin
            owner_tbl[id] = OWN_HW;
            rx_target     = id;
            rx_armed_q    = 1'b1;
        end
    endfunction

    function automatic result_t apply_operation(input logic [OP_W-1:0] op,
                                                input logic [2:0] id,
                                                input logic [LEN_W-1:0] len);
        result_t    r;
        status_t    st;
        logic [2:0] grant;
        logic [2:0] n;
        st    = ST_OK;
        grant = '0;
        case (op)
            OP_CLAIM_RX: begin
                // round-robin, starting after the last packet claimed
                st = ST_NOBUF;
                n  = last_claim_id;
                for (int i = 0; i < NUM_BUFFERS; i++) begin
                    n = n + 3'd1;
                    if (owner_tbl[n] == OWN_VALID) begin
                        owner_tbl[n]  = OWN_CPU;
                        last_claim_id = n;
                        grant         = n;
                        st            = ST_OK;
                        break;
                    end
                end
            end
            OP_CLAIM_FREE: begin
                st = ST_NOBUF;
                for (int i = 0; i < NUM_BUFFERS; i++) begin
                    if (owner_tbl[i] == OWN_FREE) begin
                        owner_tbl[i] = OWN_CPU;
                        grant        = 3'(i);
                        st           = ST_OK;
                        break;
                    end
                end
            end
            OP_START_TX: begin
                if (tx_busy_q) begin
                    st = ST_TXBUSY;
                end else if (owner_tbl[id] != OWN_CPU) begin
                    st = ST_NOTCPU;
                end else begin
                    owner_tbl[id] = OWN_HW;
                    tx_source     = id;
                    tx_len_q      = (len > LEN_W'(MAX_FRAME)) ? LEN_W'(MAX_FRAME) : len;
                    tx_busy_q     = 1'b1;
                end
            end
            OP_FREE: begin
                if (owner_tbl[id] == OWN_CPU)
                    release_buffer(id);
            end
            OP_RX_DONE: begin
                st = ST_NOBUF;
                if (rx_armed_q) begin
                    owner_tbl[rx_target] = OWN_VALID;
                    rx_armed_q = 1'b0;
                    n = rx_target;
                    for (int i = 0; i < NUM_BUFFERS; i++) begin
                        n = n + 3'd1;
                        if (owner_tbl[n] == OWN_FREE) begin
                            owner_tbl[n] = OWN_HW;
                            rx_target    = n;
                            rx_armed_q   = 1'b1;
                            st           = ST_OK;
                            break;
                        end
                    end
                end
            end
            OP_TX_DONE: begin
                if (tx_busy_q) begin
                    tx_busy_q = 1'b0;
                    release_buffer(tx_source);
                end
            end
            default: ;
        endcase
        r.status       = st;
        r.granted_id   = grant;
        r.rx_target_id = rx_target;
        r.rx_armed     = rx_armed_q;
        r.tx_source_id = tx_source;
        r.tx_length    = tx_len_q;
        r.tx_active    = tx_busy_q;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender: one item per call. Valid stays high into the next call unless
    // a gap is drawn, so back-to-back items never toggle s_tvalid in a step.
    // ------------------------------------------------------------------
    task automatic send_op(input logic [OP_W-1:0] op, input logic [2:0] id,
                           input logic [LEN_W-1:0] len);
        s_tdata  <= {{(S_TDATA_W - OP_W - ID_FIELD_W - LEN_W){1'b0}}, len, id, op};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        pool_results.push_back(apply_operation(op, id, len));
        if (sender_gap_pct != 0 && $urandom_range(99) < sender_gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker and watchdog, both sampled at the rising edge.
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [31:0] expv,
                                        input logic [31:0] actv);
        if (actv !== expv) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
                $display("result %0d: %s expected %0d got %0d",
                         result_index, name, expv, actv);
        end
    endfunction

    int unsigned quiet_cycles = 0;

    always @(posedge aclk) begin
        result_t exp_r;
        result_t got_r;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got_r = m_tdata[RES_W-1:0];
                if (pool_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("result %0d: unexpected item, data %h",
                                 result_index, m_tdata);
                end else begin
                    exp_r = pool_results.pop_front();
                    check_field("status",        32'(exp_r.status),
                                32'(got_r.status));
                    check_field("granted_id",    32'(exp_r.granted_id),
                                32'(got_r.granted_id));
                    check_field("rx_target_id",  32'(exp_r.rx_target_id),
                                32'(got_r.rx_target_id));
                    check_field("rx_armed",      32'(exp_r.rx_armed),
                                32'(got_r.rx_armed));
                    check_field("tx_source_id",  32'(exp_r.tx_source_id),
                                32'(got_r.tx_source_id));
                    check_field("tx_length_out", 32'(exp_r.tx_length),
                                32'(got_r.tx_length));
                    check_field("tx_active",     32'(exp_r.tx_active),
                                32'(got_r.tx_active));
                    check_field("pad bits",      '0,
                                32'(m_tdata[M_TDATA_W-1:RES_W]));
                end
                result_index++;
            end
            // hang detection: nothing moved on either channel for too long
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Receiver: random m_tready stalls while stall_pct is set.
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && stall_pct != 0 && $urandom_range(99) < stall_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [LEN_W-1:0] pick_length();
        case ($urandom_range(9))
            0:       return '0;
            1:       return LEN_W'(MAX_FRAME);
            2:       return '1;
            3:       return LEN_W'(MAX_FRAME + 1);
            4, 5:    return LEN_W'($urandom_range(MAX_FRAME + 2, 4095));
            default: return LEN_W'($urandom_range(1, MAX_FRAME - 1));
        endcase
    endfunction

    // Mostly a CPU-owned buffer, so start tx and free actually do something;
    // otherwise any index, which exercises the refusal paths.
    function automatic logic [2:0] pick_buffer();
        logic [2:0] cpu_ids [$];
        for (int i = 0; i < NUM_BUFFERS; i++)
            if (owner_tbl[i] == OWN_CPU)
                cpu_ids.push_back(3'(i));
        if (cpu_ids.size() != 0 && $urandom_range(4) != 0)
            return cpu_ids[$urandom_range(cpu_ids.size() - 1)];
        return 3'($urandom_range(NUM_BUFFERS - 1));
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 15)      return OP_CLAIM_RX;
        else if (roll < 30) return OP_CLAIM_FREE;
        else if (roll < 46) return OP_START_TX;
        else if (roll < 62) return OP_FREE;
        else if (roll < 80) return OP_RX_DONE;
        else if (roll < 95) return OP_TX_DONE;
        else if (roll < 97) return OP_SPARE_LO;
        else                return OP_SPARE_HI;
    endfunction

    task automatic run_random_items(input int unsigned count);
        logic [OP_W-1:0] op;
        for (int unsigned k = 0; k < count; k++) begin
            op = pick_op();
            send_op(op, pick_buffer(), pick_length());
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Walks the pool from reset through every operation and corner: empty
    // claims, refusals, length saturation, starving and re-arming the receiver.
    task automatic test_directed_cases();
        sender_gap_pct = 30;
        stall_pct      = 30;
        send_op(OP_CLAIM_RX,   3'd0, 12'd0);        // nothing received yet
        send_op(OP_TX_DONE,    3'd0, 12'd0);        // transmitter idle: ignored
        send_op(OP_START_TX,   3'd1, 12'd0);        // buffer 1 free, not CPU-owned
        send_op(OP_FREE,       3'd0, 12'd0);        // buffer 0 is the rx target
        send_op(OP_SPARE_LO,   3'd7, '1);
        send_op(OP_SPARE_HI,   3'd7, '1);
        send_op(OP_CLAIM_FREE, 3'd0, 12'd0);        // grants 1
        send_op(OP_START_TX,   3'd1, '1);           // length saturates
        send_op(OP_CLAIM_FREE, 3'd0, 12'd0);        // grants 2
        send_op(OP_START_TX,   3'd2, 12'd5);        // transmitter busy
        send_op(OP_TX_DONE,    3'd0, 12'd0);
        send_op(OP_START_TX,   3'd2, LEN_W'(MAX_FRAME));
        send_op(OP_TX_DONE,    3'd0, 12'd0);
        send_op(OP_RX_DONE,    3'd0, 12'd0);        // 0 holds a packet, rx moves on
        send_op(OP_CLAIM_RX,   3'd0, 12'd0);        // round-robin wraps to 0
        repeat (NUM_BUFFERS - 1)
            send_op(OP_CLAIM_FREE, 3'd0, 12'd0);    // drains the free list, last fails
        send_op(OP_RX_DONE,    3'd0, 12'd0);        // no next buffer: receiver disarms
        send_op(OP_RX_DONE,    3'd0, 12'd0);        // disarmed: refused
        send_op(OP_FREE,       3'd7, 12'd0);        // freed buffer re-arms receiver
        send_op(OP_RX_DONE,    3'd0, 12'd0);        // starve it again
        send_op(OP_START_TX,   3'd3, 12'd1);
        send_op(OP_TX_DONE,    3'd0, 12'd0);        // tx buffer re-arms receiver
        send_op(OP_CLAIM_RX,   3'd0, 12'd0);
    endtask

    // Bulk random traffic; the idling mix changes every hundred items so that
    // bursty and gap-free stretches both occur.
    task automatic test_random_with_idling();
        int unsigned gap_choice [3] = '{0, 20, 50};
        for (int blk = 0; blk < 15; blk++) begin
            sender_gap_pct = gap_choice[$urandom_range(2)];
            stall_pct      = gap_choice[$urandom_range(2)];
            run_random_items(100);
        end
    endtask

    // Last stretch at full rate on both sides.
    task automatic test_random_back_to_back();
        sender_gap_pct = 0;
        stall_pct      = 0;
        run_random_items(300);
    endtask

    initial begin
        // predictor mirrors the reset state: buffer 0 is the armed rx target
        foreach (owner_tbl[i])
            owner_tbl[i] = OWN_FREE;
        owner_tbl[0]  = OWN_HW;
        last_claim_id = '0;
        rx_target     = '0;
        rx_armed_q    = 1'b1;
        tx_source     = '0;
        tx_busy_q     = 1'b0;
        tx_len_q      = '0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_random_with_idling();
        test_random_back_to_back();
        s_tvalid <= 1'b0;

        // every outstanding result must arrive; the watchdog bounds this wait
        while (pool_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
